// ===== rtl/core/fcte_pkg.sv =====
// Shared types, codes and entry packing helpers for the FAT12 cluster table engine.
`timescale 1ns / 1ps

package fcte_pkg;

  localparam int MODE_W    = 3;
  localparam int CLUSTER_W = 12;
  localparam int BIDX_W    = 13;
  localparam int BYTE_W    = 8;
  localparam int STATUS_W  = 2;
  localparam int LIMIT_W   = 13;
  localparam int PAIR_W    = 16;

  localparam logic [CLUSTER_W-1:0] ENTRY_FREE    = 12'h000;
  localparam logic [CLUSTER_W-1:0] ENTRY_EOC     = 12'hFFF;
  localparam logic [CLUSTER_W-1:0] ENTRY_EOC_MIN = 12'hFF8;
  localparam logic [LIMIT_W-1:0]   FIRST_DATA    = 13'd2;
  localparam logic [LIMIT_W-1:0]   ENTRY_MAX     = 13'd4096;

  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD_BYTE   = 3'd0,
    MODE_READ_BYTE   = 3'd1,
    MODE_READ_ENTRY  = 3'd2,
    MODE_WRITE_ENTRY = 3'd3,
    MODE_ALLOCATE    = 3'd4,
    MODE_FREE_CHAIN  = 3'd5
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_NOFREE = 2'd1,
    ST_RANGE  = 2'd2,
    ST_LONG   = 2'd3
  } status_t;

  // Access request from the sequencer to the banked table store.
  typedef struct packed {
    logic                 en;
    logic                 we;
    logic                 byte_mode;
    logic [CLUSTER_W-1:0] cluster;
    logic [BIDX_W-1:0]    bidx;
    logic [BYTE_W-1:0]    wbyte;
    logic [PAIR_W-1:0]    wpair;
  } tbl_req_t;

  // Read data, valid in the cycle after a read request.
  typedef struct packed {
    logic [PAIR_W-1:0] pair;
    logic [BYTE_W-1:0] rbyte;
  } tbl_rsp_t;

  // Odd entries sit in the upper twelve bits of the byte pair, even ones in the lower.
  function automatic logic [CLUSTER_W-1:0] entry_get(input logic [PAIR_W-1:0] pair,
                                                     input logic odd);
    return odd ? pair[15:4] : pair[11:0];
  endfunction

  function automatic logic [PAIR_W-1:0] entry_put(input logic [PAIR_W-1:0] pair,
                                                  input logic odd,
                                                  input logic [CLUSTER_W-1:0] v);
    return odd ? {v, pair[3:0]} : {pair[15:12], v};
  endfunction

endpackage

// ===== rtl/core/fcte_ifs.sv =====
// Valid/ready channel interfaces for the FAT12 cluster table engine.
`timescale 1ns / 1ps

interface fcte_in_if import fcte_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [MODE_W-1:0]    mode;
  logic [CLUSTER_W-1:0] cluster;
  logic [CLUSTER_W-1:0] entry_value;
  logic                 link_previous;
  logic [BIDX_W-1:0]    byte_index;
  logic [BYTE_W-1:0]    byte_data;

  modport source (output valid, mode, cluster, entry_value, link_previous, byte_index,
                  byte_data, input ready);
  modport sink (input valid, mode, cluster, entry_value, link_previous, byte_index,
                byte_data, output ready);
endinterface

interface fcte_out_if import fcte_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CLUSTER_W-1:0] entry_out;
  logic [BYTE_W-1:0]    byte_out;
  logic [STATUS_W-1:0]  status;

  modport source (output valid, entry_out, byte_out, status, input ready);
  modport sink (input valid, entry_out, byte_out, status, output ready);
endinterface

// ===== rtl/core/fcte_ram.sv =====
// Generic single-port synchronous RAM with a registered read.
`timescale 1ns / 1ps

module fcte_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 3072
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

// ===== rtl/core/fcte_table.sv =====
// Table image store split into even and odd byte banks, with entry and byte addressing.
`timescale 1ns / 1ps

module fcte_table import fcte_pkg::*; #(
  parameter int TABLE_BYTES = 6144
) (
  input  logic     clk,
  input  tbl_req_t req,
  output tbl_rsp_t rsp
);

  localparam int BANK_DEPTH = TABLE_BYTES / 2;
  localparam int BANK_AW    = $clog2(BANK_DEPTH);

  logic [BIDX_W-1:0]  at;
  logic [BIDX_W-2:0]  base;
  logic [BIDX_W-2:0]  base_p1;
  logic [BIDX_W-2:0]  bidx_hi;
  logic               at_odd;
  logic               b0_en, b1_en;
  logic [BANK_AW-1:0] b0_addr, b1_addr;
  logic [BYTE_W-1:0]  b0_wdata, b1_wdata;
  logic [BYTE_W-1:0]  b0_q, b1_q;
  logic               odd_r, bsel_r;

  // Entry c starts at byte 3c/2; the two bytes always fall in different banks.
  assign at      = BIDX_W'(req.cluster) + BIDX_W'(req.cluster >> 1);
  assign at_odd  = at[0];
  assign base    = at[BIDX_W-1:1];
  assign base_p1 = base + 1'b1;
  assign bidx_hi = req.bidx[BIDX_W-1:1];

  always_comb begin
    if (req.byte_mode) begin
      b0_en    = req.en & ~req.bidx[0];
      b1_en    = req.en & req.bidx[0];
      b0_addr  = bidx_hi[BANK_AW-1:0];
      b1_addr  = bidx_hi[BANK_AW-1:0];
      b0_wdata = req.wbyte;
      b1_wdata = req.wbyte;
    end else begin
      b0_en    = req.en;
      b1_en    = req.en;
      b0_addr  = at_odd ? base_p1[BANK_AW-1:0] : base[BANK_AW-1:0];
      b1_addr  = base[BANK_AW-1:0];
      b0_wdata = at_odd ? req.wpair[15:8] : req.wpair[7:0];
      b1_wdata = at_odd ? req.wpair[7:0] : req.wpair[15:8];
    end
  end

  always_ff @(posedge clk) begin
    if (req.en) begin
      odd_r  <= at_odd;
      bsel_r <= req.bidx[0];
    end
  end

  fcte_ram #(.WIDTH(BYTE_W), .DEPTH(BANK_DEPTH)) u_bank_even (
    .clk   (clk),
    .en    (b0_en),
    .we    (req.we),
    .addr  (b0_addr),
    .wdata (b0_wdata),
    .rdata (b0_q)
  );

  fcte_ram #(.WIDTH(BYTE_W), .DEPTH(BANK_DEPTH)) u_bank_odd (
    .clk   (clk),
    .en    (b1_en),
    .we    (req.we),
    .addr  (b1_addr),
    .wdata (b1_wdata),
    .rdata (b1_q)
  );

  assign rsp.pair  = odd_r ? {b0_q, b1_q} : {b1_q, b0_q};
  assign rsp.rbyte = bsel_r ? b1_q : b0_q;

endmodule

// ===== rtl/core/fcte_seq.sv =====
// Sequencer that runs each mode as read, write or read-modify-write steps on the table store.
`timescale 1ns / 1ps

module fcte_seq import fcte_pkg::*; #(
  parameter int TABLE_BYTES = 6144
) (
  input  logic               clk,
  input  logic               rst_n,
  fcte_in_if.sink            in_ch,
  fcte_out_if.source         out_ch,
  input  logic               cfg_we,
  input  logic [LIMIT_W-1:0] cfg_wdata,
  output tbl_req_t           req,
  input  tbl_rsp_t           rsp
);

  localparam int FIT_ENTRIES = TABLE_BYTES * 2 / 3;
  localparam logic [LIMIT_W-1:0] MAX_LIMIT =
    (FIT_ENTRIES < 4096) ? LIMIT_W'(FIT_ENTRIES) : ENTRY_MAX;
  localparam logic [BIDX_W-1:0] IMAGE_BYTES = BIDX_W'(TABLE_BYTES);

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_BYTE_WAIT, S_ENT_EVAL, S_ALLOC_RD, S_ALLOC_CHK,
    S_LINK_RD, S_LINK_WR, S_FREE_CHK, S_FREE_EVAL, S_RESP
  } state_t;

  state_t               state_r, state_nxt;
  logic [MODE_W-1:0]    mode_r, mode_nxt;
  logic [CLUSTER_W-1:0] cl_r, cl_nxt;
  logic [CLUSTER_W-1:0] val_r, val_nxt;
  logic                 link_r, link_nxt;
  logic [BIDX_W-1:0]    bi_r, bi_nxt;
  logic [BYTE_W-1:0]    bd_r, bd_nxt;
  logic [LIMIT_W-1:0]   cur_r, cur_nxt;
  logic [LIMIT_W-1:0]   steps_r, steps_nxt;
  logic [LIMIT_W-1:0]   lim_r, lim_nxt;
  logic [CLUSTER_W-1:0] eo_r, eo_nxt;
  logic [BYTE_W-1:0]    bo_r, bo_nxt;
  status_t              st_r, st_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [CLUSTER_W-1:0] out_entry_r, out_entry_nxt;
  logic [BYTE_W-1:0]    out_byte_r, out_byte_nxt;
  status_t              out_status_r, out_status_nxt;
  logic [CLUSTER_W-1:0] rd_entry;
  logic [LIMIT_W-1:0]   cl_ext;

  assign cl_ext   = LIMIT_W'(cl_r);
  assign rd_entry = entry_get(rsp.pair, req.cluster[0]);

  always_comb begin
    state_nxt      = state_r;
    mode_nxt       = mode_r;
    cl_nxt         = cl_r;
    val_nxt        = val_r;
    link_nxt       = link_r;
    bi_nxt         = bi_r;
    bd_nxt         = bd_r;
    cur_nxt        = cur_r;
    steps_nxt      = steps_r;
    lim_nxt        = lim_r;
    eo_nxt         = eo_r;
    bo_nxt         = bo_r;
    st_nxt         = st_r;
    out_valid_nxt  = out_valid_r;
    out_entry_nxt  = out_entry_r;
    out_byte_nxt   = out_byte_r;
    out_status_nxt = out_status_r;

    req           = '0;
    req.cluster   = cur_r[CLUSTER_W-1:0];
    req.bidx      = bi_r;
    req.wbyte     = bd_r;

    if (cfg_we) begin
      if (cfg_wdata > MAX_LIMIT) begin
        lim_nxt = MAX_LIMIT;
      end else if (cfg_wdata < FIRST_DATA) begin
        lim_nxt = FIRST_DATA;
      end else begin
        lim_nxt = cfg_wdata;
      end
    end

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          mode_nxt  = in_ch.mode;
          cl_nxt    = in_ch.cluster;
          val_nxt   = in_ch.entry_value;
          link_nxt  = in_ch.link_previous;
          bi_nxt    = in_ch.byte_index;
          bd_nxt    = in_ch.byte_data;
          eo_nxt    = '0;
          bo_nxt    = '0;
          st_nxt    = ST_OK;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        state_nxt = S_RESP;
        case (mode_r)
          MODE_LOAD_BYTE: begin
            if (bi_r < IMAGE_BYTES) begin
              req.en        = 1'b1;
              req.we        = 1'b1;
              req.byte_mode = 1'b1;
            end else begin
              st_nxt = ST_RANGE;
            end
          end
          MODE_READ_BYTE: begin
            if (bi_r < IMAGE_BYTES) begin
              req.en        = 1'b1;
              req.byte_mode = 1'b1;
              state_nxt     = S_BYTE_WAIT;
            end else begin
              st_nxt = ST_RANGE;
            end
          end
          MODE_READ_ENTRY, MODE_WRITE_ENTRY: begin
            if (cl_ext < lim_r) begin
              req.cluster = cl_r;
              req.en      = 1'b1;
              cur_nxt     = cl_ext;
              state_nxt   = S_ENT_EVAL;
            end else begin
              st_nxt = ST_RANGE;
            end
          end
          MODE_ALLOCATE: begin
            if (link_r && cl_ext >= lim_r) begin
              st_nxt = ST_RANGE;
            end else begin
              cur_nxt   = FIRST_DATA;
              state_nxt = S_ALLOC_RD;
            end
          end
          MODE_FREE_CHAIN: begin
            cur_nxt   = cl_ext;
            steps_nxt = '0;
            state_nxt = S_FREE_CHK;
          end
          default: begin
            state_nxt = S_RESP;
          end
        endcase
      end
      S_BYTE_WAIT: begin
        bo_nxt    = rsp.rbyte;
        state_nxt = S_RESP;
      end
      S_ENT_EVAL: begin
        if (mode_r == MODE_READ_ENTRY) begin
          eo_nxt = rd_entry;
        end else begin
          req.en    = 1'b1;
          req.we    = 1'b1;
          req.wpair = entry_put(rsp.pair, cur_r[0], val_r);
        end
        state_nxt = S_RESP;
      end
      S_ALLOC_RD: begin
        if (cur_r >= lim_r) begin
          st_nxt    = ST_NOFREE;
          state_nxt = S_RESP;
        end else begin
          req.en    = 1'b1;
          state_nxt = S_ALLOC_CHK;
        end
      end
      S_ALLOC_CHK: begin
        if (rd_entry == ENTRY_FREE) begin
          req.en    = 1'b1;
          req.we    = 1'b1;
          req.wpair = entry_put(rsp.pair, cur_r[0], ENTRY_EOC);
          eo_nxt    = cur_r[CLUSTER_W-1:0];
          state_nxt = link_r ? S_LINK_RD : S_RESP;
        end else begin
          cur_nxt   = cur_r + 1'b1;
          state_nxt = S_ALLOC_RD;
        end
      end
      S_LINK_RD: begin
        req.cluster = cl_r;
        req.en      = 1'b1;
        state_nxt   = S_LINK_WR;
      end
      S_LINK_WR: begin
        req.cluster = cl_r;
        req.en      = 1'b1;
        req.we      = 1'b1;
        req.wpair   = entry_put(rsp.pair, cl_r[0], eo_r);
        state_nxt   = S_RESP;
      end
      S_FREE_CHK: begin
        if (cur_r < FIRST_DATA || cur_r >= LIMIT_W'(ENTRY_EOC_MIN)) begin
          state_nxt = S_RESP;
        end else if (cur_r >= lim_r) begin
          st_nxt    = ST_RANGE;
          state_nxt = S_RESP;
        end else if (steps_r >= lim_r) begin
          st_nxt    = ST_LONG;
          state_nxt = S_RESP;
        end else begin
          steps_nxt = steps_r + 1'b1;
          req.en    = 1'b1;
          state_nxt = S_FREE_EVAL;
        end
      end
      S_FREE_EVAL: begin
        req.en    = 1'b1;
        req.we    = 1'b1;
        req.wpair = entry_put(rsp.pair, cur_r[0], ENTRY_FREE);
        if (rd_entry >= ENTRY_EOC_MIN) begin
          state_nxt = S_RESP;
        end else begin
          cur_nxt   = LIMIT_W'(rd_entry);
          state_nxt = S_FREE_CHK;
        end
      end
      S_RESP: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_entry_nxt  = eo_r;
          out_byte_nxt   = bo_r;
          out_status_nxt = st_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    mode_r       <= mode_nxt;
    cl_r         <= cl_nxt;
    val_r        <= val_nxt;
    link_r       <= link_nxt;
    bi_r         <= bi_nxt;
    bd_r         <= bd_nxt;
    cur_r        <= cur_nxt;
    steps_r      <= steps_nxt;
    eo_r         <= eo_nxt;
    bo_r         <= bo_nxt;
    st_r         <= st_nxt;
    out_entry_r  <= out_entry_nxt;
    out_byte_r   <= out_byte_nxt;
    out_status_r <= out_status_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      lim_r       <= MAX_LIMIT;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      lim_r       <= lim_nxt;
    end
  end

  assign in_ch.ready      = (state_r == S_IDLE);
  assign out_ch.valid     = out_valid_r;
  assign out_ch.entry_out = out_entry_r;
  assign out_ch.byte_out  = out_byte_r;
  assign out_ch.status    = out_status_r;

endmodule

// ===== rtl/core/fat12_cluster_table_engine_top.sv =====
// Top level of the FAT12 cluster table engine: sequencer plus banked table store.
// Items are taken one at a time: a new item is accepted only in idle, once the previous result
// has gone to the result register. Reset is synchronous and active low; it clears control and
// sets the cluster limit to the number of entries that fit the table, at most 4096.
// The table image itself is not cleared and reads as unknown until it has been written.
`timescale 1ns / 1ps

module fat12_cluster_table_engine_top import fcte_pkg::*; #(
  parameter int TABLE_BYTES = 6144
) (
  input  logic               clk,
  input  logic               rst_n,
  fcte_in_if.sink            in_ch,
  fcte_out_if.source         out_ch,
  input  logic               cfg_we,
  input  logic [LIMIT_W-1:0] cfg_wdata
);

  // The image lives in two byte banks, even and odd byte addresses. A 12-bit entry always
  // spans one byte of each bank, so both bytes of an entry are read or written in one access.
  // Every mode is a short sequence of accesses; an entry update is a read followed in the next
  // cycle by the modified write-back, so no two accesses to the same entry ever overlap.
  tbl_req_t tbl_req;
  tbl_rsp_t tbl_rsp;

  // The sequencer holds the item, the clamped cluster limit and the result register. The
  // result register lets the last transaction wait on the output side while the sequencer
  // returns to idle and takes the next input transaction.
  fcte_seq #(.TABLE_BYTES(TABLE_BYTES)) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (tbl_req),
    .rsp       (tbl_rsp)
  );

  // Allocation scans upward from cluster 2, reading and then checking each entry, and the chain
  // walk of the free mode reads and frees one link at a time; both are bounded by the cluster limit.
  fcte_table #(.TABLE_BYTES(TABLE_BYTES)) u_table (
    .clk (clk),
    .req (tbl_req),
    .rsp (tbl_rsp)
  );

endmodule

// ===== rtl/core/fcte_checker.sv =====
// Port-level assertions for the FAT12 cluster table engine and their bind.
`timescale 1ns / 1ps

module fcte_checker import fcte_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [CLUSTER_W-1:0] entry_out,
  input logic [BYTE_W-1:0]    byte_out,
  input logic [STATUS_W-1:0]  status
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(entry_out) && $stable(byte_out)
      && $stable(status))
    else $error("result changed while stalled");

  a_reset_clears: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid right after reset");

  a_byte_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && byte_out != '0 |-> status == ST_OK && entry_out == '0)
    else $error("byte result mixed with entry result or error");

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status == ST_NOFREE || status == ST_RANGE) |->
      entry_out == '0 && byte_out == '0)
    else $error("error result carries data");

endmodule

bind fat12_cluster_table_engine_top fcte_checker u_fcte_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .entry_out (out_ch.entry_out),
  .byte_out  (out_ch.byte_out),
  .status    (out_ch.status)
);
